[sv/wsrd_pkg.sv]
package wsrd_pkg;

  // Field widths
  localparam int unsigned SPEED_W   = 8;
  localparam int unsigned DEMAND_W  = 10;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned LEAD_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [SPEED_W-1:0]   speed_t;
  typedef logic [DEMAND_W-1:0]  demand_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [LEAD_W-1:0]    lead_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t REG_ACCEL_KNEE      = 3'd0;
  localparam cfg_idx_t REG_ACCEL_FAST_STEP = 3'd1;
  localparam cfg_idx_t REG_DECEL_KNEE      = 3'd2;
  localparam cfg_idx_t REG_DECEL_FAST_STEP = 3'd3;
  localparam cfg_idx_t REG_SPEED_CAP       = 3'd4;
  localparam cfg_idx_t REG_SPEED_FLOOR     = 3'd5;

  // Register reset values
  localparam speed_t RST_ACCEL_KNEE      = 8'd50;
  localparam step_t  RST_ACCEL_FAST_STEP = 4'd3;
  localparam speed_t RST_DECEL_KNEE      = 8'd150;
  localparam step_t  RST_DECEL_FAST_STEP = 4'd2;
  localparam speed_t RST_SPEED_CAP       = 8'd250;
  localparam speed_t RST_SPEED_FLOOR     = 8'd3;

  // Target value that means stop
  localparam speed_t STOP_CODE = 8'd2;

  // Leader wheel codes
  localparam lead_t LEAD_WHEEL0 = 2'd0;
  localparam lead_t LEAD_WHEEL4 = 2'd1;
  localparam lead_t LEAD_WHEEL8 = 2'd2;

  typedef struct packed {
    speed_t accel_knee;
    step_t  accel_fast_step;
    speed_t decel_knee;
    step_t  decel_fast_step;
    speed_t speed_cap;
    speed_t speed_floor;
  } cfg_regs_t;

endpackage

[sv/wsrd_cfg.sv]
module wsrd_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  wsrd_pkg::cfg_idx_t  cfg_index,
  input  wsrd_pkg::speed_t    cfg_data,
  output wsrd_pkg::cfg_regs_t regs
);
  import wsrd_pkg::*;

  // Writes are always accepted; cfg_ready is tied high
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.accel_knee      <= RST_ACCEL_KNEE;
      regs.accel_fast_step <= RST_ACCEL_FAST_STEP;
      regs.decel_knee      <= RST_DECEL_KNEE;
      regs.decel_fast_step <= RST_DECEL_FAST_STEP;
      regs.speed_cap       <= RST_SPEED_CAP;
      regs.speed_floor     <= RST_SPEED_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEL_KNEE:      regs.accel_knee      <= cfg_data;
        REG_ACCEL_FAST_STEP: regs.accel_fast_step <= cfg_data[STEP_W-1:0];
        REG_DECEL_KNEE:      regs.decel_knee      <= cfg_data;
        REG_DECEL_FAST_STEP: regs.decel_fast_step <= cfg_data[STEP_W-1:0];
        REG_SPEED_CAP:       regs.speed_cap       <= cfg_data;
        REG_SPEED_FLOOR:     regs.speed_floor     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/wsrd_ramp.sv]
module wsrd_ramp (
  input  logic                clk,
  input  logic                rst,
  input  wsrd_pkg::cfg_regs_t regs,
  input  logic                enable,
  input  wsrd_pkg::speed_t    target,
  output wsrd_pkg::speed_t    speed_next
);
  import wsrd_pkg::*;

  speed_t              speed;
  logic                phase;
  logic                phase_next;
  step_t               acc_step;
  step_t               dec_step;
  logic [SPEED_W:0]    acc_sum;
  logic signed [SPEED_W+1:0] dec_diff;

  // Step sizes around the knees
  assign acc_step = (speed < regs.accel_knee) ? step_t'(1) : regs.accel_fast_step;
  assign dec_step = (speed > regs.decel_knee) ? regs.decel_fast_step : step_t'(1);
  assign acc_sum  = {1'b0, speed} + {{(SPEED_W+1-STEP_W){1'b0}}, acc_step};
  assign dec_diff = $signed({2'b00, speed}) - $signed({{(SPEED_W+2-STEP_W){1'b0}}, dec_step});

  // Next common speed, clamped at the target
  always_comb begin
    speed_next = speed;
    phase_next = phase;
    if (speed < target) begin
      phase_next = ~phase;
      if (!phase) begin
        speed_next = (acc_sum >= {1'b0, target}) ? target : acc_sum[SPEED_W-1:0];
      end
    end else if (speed > target) begin
      phase_next = ~phase;
      speed_next = (dec_diff <= $signed({2'b00, target})) ? target : dec_diff[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      phase <= 1'b0;
    end else if (enable) begin
      speed <= speed_next;
      phase <= phase_next;
    end
  end

endmodule

[sv/wsrd_dist.sv]
module wsrd_dist (
  input  wsrd_pkg::cfg_regs_t regs,
  input  wsrd_pkg::speed_t    common,
  input  wsrd_pkg::speed_t    target,
  input  wsrd_pkg::demand_t   demand0,
  input  wsrd_pkg::demand_t   demand4,
  input  wsrd_pkg::demand_t   demand8,
  output wsrd_pkg::speed_t    speed0,
  output wsrd_pkg::speed_t    speed4,
  output wsrd_pkg::speed_t    speed8,
  output wsrd_pkg::lead_t     lead
);
  import wsrd_pkg::*;

  localparam int unsigned V_W = DEMAND_W + 2;

  demand_t              d [3];
  demand_t              d_lead;
  demand_t              gap [3];
  logic signed [V_W-1:0] v [3];
  speed_t               lim [3];
  logic                 stop;

  assign d[0] = demand0;
  assign d[1] = demand4;
  assign d[2] = demand8;
  assign stop = (target == STOP_CODE);

  // Leader: strictly larger demand wins, ties go to the lower wheel
  always_comb begin
    lead = (d[1] > d[0]) ? LEAD_WHEEL4 : LEAD_WHEEL0;
    d_lead = (lead == LEAD_WHEEL4) ? d[1] : d[0];
    if (d[2] > d_lead) begin
      lead = LEAD_WHEEL8;
      d_lead = d[2];
    end
  end

  // Per wheel: subtract demand gap, then cap and floor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gap[i] = (d_lead > d[i]) ? (d_lead - d[i]) : (d[i] - d_lead);
      v[i]   = $signed({{(V_W-SPEED_W){1'b0}}, common})
             - $signed({{(V_W-DEMAND_W){1'b0}}, gap[i]});
      if (v[i] > $signed({{(V_W-SPEED_W){1'b0}}, regs.speed_cap})) begin
        lim[i] = regs.speed_cap;
      end else if (v[i] <= $signed({{(V_W-SPEED_W){1'b0}}, regs.speed_floor})) begin
        lim[i] = stop ? STOP_CODE : regs.speed_floor;
      end else begin
        lim[i] = v[i][SPEED_W-1:0];
      end
    end
  end

  assign speed0 = lim[0];
  assign speed4 = lim[1];
  assign speed8 = lim[2];

endmodule

[sv/wheel_speed_ramp_distributor.sv]
// Wheel speed ramp distributor.
// One request on the input channel is one control tick: a target speed and
// three wheel demands. Each tick yields exactly one result: three limited
// wheel speeds, the ramped common speed and the leader wheel index.
// Input channel: in_valid / in_stall; output channel: out_valid / out_stall.
// A request is taken when valid is high and stall is low.
// Path: a taken request waits in the input register; when it advances, its
// result is written to the result register and shown on the outputs.
// Throughput: one request per cycle while out_stall is low; the ramp, leader
// search and limiting fit between the input register and the result register.
// When out_stall holds a result, the input register still takes one more
// request; in_stall rises only once both registers are full.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; writes
// are always accepted and must be made while no tick is in flight.
// Reset (rst, synchronous) clears both valid flags, sets common speed and
// the acceleration phase to zero and loads the register reset values.
module wheel_speed_ramp_distributor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  wsrd_pkg::cfg_idx_t cfg_index,
  input  wsrd_pkg::speed_t   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsrd_pkg::speed_t   goal_speed,
  input  wsrd_pkg::demand_t  demand_wheel0,
  input  wsrd_pkg::demand_t  demand_wheel4,
  input  wsrd_pkg::demand_t  demand_wheel8,
  output logic               out_valid,
  input  logic               out_stall,
  output wsrd_pkg::speed_t   speed_wheel0,
  output wsrd_pkg::speed_t   speed_wheel4,
  output wsrd_pkg::speed_t   speed_wheel8,
  output wsrd_pkg::speed_t   ramped_speed,
  output wsrd_pkg::lead_t    leader_wheel
);
  import wsrd_pkg::*;

  cfg_regs_t regs;
  logic      s1_valid;
  speed_t    s1_target;
  demand_t   s1_d0;
  demand_t   s1_d4;
  demand_t   s1_d8;
  logic      advance;
  logic      in_accept;
  speed_t    speed_next;
  speed_t    w0;
  speed_t    w4;
  speed_t    w8;
  lead_t     lead;

  // Handshake control
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  wsrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  wsrd_ramp u_ramp (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .enable     (advance),
    .target     (s1_target),
    .speed_next (speed_next)
  );

  wsrd_dist u_dist (
    .regs    (regs),
    .common  (speed_next),
    .target  (s1_target),
    .demand0 (s1_d0),
    .demand4 (s1_d4),
    .demand8 (s1_d8),
    .speed0  (w0),
    .speed4  (w4),
    .speed8  (w8),
    .lead    (lead)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_target <= goal_speed;
      s1_d0     <= demand_wheel0;
      s1_d4     <= demand_wheel4;
      s1_d8     <= demand_wheel8;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      speed_wheel0 <= w0;
      speed_wheel4 <= w4;
      speed_wheel8 <= w8;
      ramped_speed <= speed_next;
      leader_wheel <= lead;
    end
  end

`ifndef SYNTHESIS
  // A held request is never dropped from the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input register lost a request");

  // Every advance produces a result
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advance without result");

  // Leader code is one of the three wheels
  a_lead_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (leader_wheel == LEAD_WHEEL0 || leader_wheel == LEAD_WHEEL4 ||
                   leader_wheel == LEAD_WHEEL8))
    else $error("bad leader code");

  // When wheel 0 leads, it gets the common speed if that lies inside the limits
  a_lead_spd: assert property (@(posedge clk) disable iff (rst)
    out_valid && leader_wheel == LEAD_WHEEL0 && ramped_speed <= regs.speed_cap &&
    ramped_speed > regs.speed_floor |-> speed_wheel0 == ramped_speed)
    else $error("leader speed differs from common speed");
`endif

endmodule

[tb/sv/tb_wheel_speed_ramp_distributor.sv]
module tb_wheel_speed_ramp_distributor;
  timeunit 1ns;
  timeprecision 1ps;

  import wsrd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_TICKS  = 1600;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 3;

  // Indexes that map to no register; writes there must be ignored
  localparam cfg_idx_t CFG_IDX_UNMAPPED_A = 3'd6;
  localparam cfg_idx_t CFG_IDX_UNMAPPED_B = 3'd7;

  typedef struct packed {
    speed_t speed_wheel0;
    speed_t speed_wheel4;
    speed_t speed_wheel8;
    speed_t ramped_speed;
    lead_t  leader_wheel;
  } wheel_result_t;

  // Tracks ramp state and registers, predicts each tick's wheel speeds
  class ramp_tracker;
    cfg_regs_t     regs;
    speed_t        speed;
    bit            phase;
    wheel_result_t due[$];
    int            n_bad;

    function new();
      regs.accel_knee      = RST_ACCEL_KNEE;
      regs.accel_fast_step = RST_ACCEL_FAST_STEP;
      regs.decel_knee      = RST_DECEL_KNEE;
      regs.decel_fast_step = RST_DECEL_FAST_STEP;
      regs.speed_cap       = RST_SPEED_CAP;
      regs.speed_floor     = RST_SPEED_FLOOR;
      speed = '0;
      phase = 1'b0;
      n_bad = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, speed_t data);
      case (idx)
        REG_ACCEL_KNEE:      regs.accel_knee      = data;
        REG_ACCEL_FAST_STEP: regs.accel_fast_step = data[STEP_W-1:0];
        REG_DECEL_KNEE:      regs.decel_knee      = data;
        REG_DECEL_FAST_STEP: regs.decel_fast_step = data[STEP_W-1:0];
        REG_SPEED_CAP:       regs.speed_cap       = data;
        REG_SPEED_FLOOR:     regs.speed_floor     = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Cap first, then floor (stop code forces 2)
    function speed_t limit(int v, speed_t tgt);
      if (v > int'(regs.speed_cap)) return regs.speed_cap;
      if (v <= int'(regs.speed_floor)) return (tgt == STOP_CODE) ? STOP_CODE : regs.speed_floor;
      return speed_t'(v);
    endfunction

    function void take_tick(speed_t tgt, demand_t dw0, demand_t dw4, demand_t dw8);
      demand_t       dem [3];
      speed_t        lim [3];
      int            s;
      int            v;
      int            span;
      int            k;
      bit            go;
      lead_t         ld;
      wheel_result_t r;
      dem[0] = dw0;
      dem[1] = dw4;
      dem[2] = dw8;
      s = int'(speed);
      // ramp: accel on every other differing tick, decel every tick, no overshoot
      if (speed < tgt) begin
        go = ~phase;
        phase = ~phase;
        if (go) begin
          s += (speed < regs.accel_knee) ? 1 : int'(regs.accel_fast_step);
          if (s >= int'(tgt)) s = int'(tgt);
        end
      end else if (speed > tgt) begin
        phase = ~phase;
        s -= (speed > regs.decel_knee) ? int'(regs.decel_fast_step) : 1;
        if (s <= int'(tgt)) s = int'(tgt);
      end
      speed = speed_t'(s);
      // leader: strictly larger demand wins, ties go to the lower wheel
      ld = LEAD_WHEEL0;
      if (dem[1] > dem[0]) ld = LEAD_WHEEL4;
      if (dem[2] > dem[ld]) ld = LEAD_WHEEL8;
      for (k = 0; k < 3; k++) begin
        v = int'(speed);
        if (k != int'(ld)) begin
          span = int'(dem[ld]) - int'(dem[k]);
          if (span < 0) span = -span;
          v -= span;
        end
        lim[k] = limit(v, tgt);
      end
      r.speed_wheel0 = lim[0];
      r.speed_wheel4 = lim[1];
      r.speed_wheel8 = lim[2];
      r.ramped_speed = speed;
      r.leader_wheel = ld;
      due.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(wheel_result_t got);
      wheel_result_t want;
      if (due.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("%0t: result with no tick pending, got %p", $time, got);
        return;
      end
      want = due.pop_front();
      check_field("speed_wheel0", want.speed_wheel0, got.speed_wheel0);
      check_field("speed_wheel4", want.speed_wheel4, got.speed_wheel4);
      check_field("speed_wheel8", want.speed_wheel8, got.speed_wheel8);
      check_field("ramped_speed", want.ramped_speed, got.ramped_speed);
      check_field("leader_wheel", want.leader_wheel, got.leader_wheel);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  speed_t   cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  speed_t   goal_speed = '0;
  demand_t  demand_wheel0 = '0;
  demand_t  demand_wheel4 = '0;
  demand_t  demand_wheel8 = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  speed_t   speed_wheel0;
  speed_t   speed_wheel4;
  speed_t   speed_wheel8;
  speed_t   ramped_speed;
  lead_t    leader_wheel;

  ramp_tracker   tracker = new();
  wheel_result_t seen;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  int            rx_hold = 0;
  int            ticks_sent = 0;
  int            cycle_count = 0;

  wheel_speed_ramp_distributor i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .goal_speed    (goal_speed),
    .demand_wheel0 (demand_wheel0),
    .demand_wheel4 (demand_wheel4),
    .demand_wheel8 (demand_wheel8),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .speed_wheel0  (speed_wheel0),
    .speed_wheel4  (speed_wheel4),
    .speed_wheel8  (speed_wheel8),
    .ramped_speed  (ramped_speed),
    .leader_wheel  (leader_wheel)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check accepted results, then stall for a random while
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.speed_wheel0 = speed_wheel0;
      seen.speed_wheel4 = speed_wheel4;
      seen.speed_wheel8 = speed_wheel8;
      seen.ramped_speed = ramped_speed;
      seen.leader_wheel = leader_wheel;
      tracker.match_result(seen);
      rx_hold = rx_calm ? 0 : $urandom_range(0, 5);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold > 0);
  end

  // One tick request; returns at the edge where it was taken
  task automatic send_tick(speed_t tgt, demand_t a, demand_t b, demand_t c);
    int wait_n;
    wait_n = tx_calm ? 0 : $urandom_range(0, 5);
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid      <= 1'b1;
    goal_speed    <= tgt;
    demand_wheel0 <= a;
    demand_wheel4 <= b;
    demand_wheel8 <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_tick(tgt, a, b, c);
    ticks_sent++;
  endtask

  // Leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(cfg_idx_t idx, speed_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_regs(speed_t ak, speed_t afs, speed_t dk, speed_t dfs,
                           speed_t cap, speed_t flr, bit junk);
    write_reg(REG_ACCEL_KNEE, ak);
    write_reg(REG_ACCEL_FAST_STEP, afs);
    write_reg(REG_DECEL_KNEE, dk);
    write_reg(REG_DECEL_FAST_STEP, dfs);
    write_reg(REG_SPEED_CAP, cap);
    write_reg(REG_SPEED_FLOOR, flr);
    if (junk)
      write_reg($urandom_range(0, 1) ? CFG_IDX_UNMAPPED_A : CFG_IDX_UNMAPPED_B,
                speed_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every pending result, then a few quiet cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic demand_t near(demand_t base);
    int v;
    v = int'(base) + $urandom_range(0, 160) - 80;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return demand_t'(v);
  endfunction

  // Mostly close demands so the gaps stay inside the speed range
  task automatic make_demands(output demand_t a, output demand_t b, output demand_t c);
    demand_t base;
    base = demand_t'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        a = demand_t'($urandom);
        b = demand_t'($urandom);
        c = demand_t'($urandom);
      end
      1, 2: begin
        a = base;
        b = $urandom_range(0, 1) ? base : near(base);
        c = $urandom_range(0, 1) ? base : near(base);
      end
      default: begin
        a = near(base);
        b = near(base);
        c = near(base);
      end
    endcase
  endtask

  function automatic speed_t pick_target();
    case ($urandom_range(0, 9))
      0, 1: return STOP_CODE;
      2:    return '0;
      3:    return 8'd255;
      default: return speed_t'($urandom);
    endcase
  endfunction

  function automatic speed_t pick_byte(speed_t rst_v);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'd255;
      2: return rst_v;
      default: return speed_t'($urandom);
    endcase
  endfunction

  // Step data: upper bits are dropped by the block
  function automatic speed_t pick_step(step_t rst_v);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 8'd1;
      2: return 8'd15;
      3: return speed_t'(rst_v);
      4: return speed_t'($urandom);
      default: return speed_t'($urandom_range(1, 15));
    endcase
  endfunction

  function automatic speed_t pick_cap();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 8'd255;
      2: return RST_SPEED_CAP;
      default: return speed_t'($urandom_range(100, 255));
    endcase
  endfunction

  function automatic speed_t pick_floor();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 8'd255;
      2: return RST_SPEED_FLOOR;
      3: return STOP_CODE;
      default: return speed_t'($urandom_range(0, 40));
    endcase
  endfunction

  // Held targets with occasional off-target noise
  task automatic run_random_phase(int n);
    int      k;
    int      hold;
    speed_t  tgt;
    demand_t a;
    demand_t b;
    demand_t c;
    hold = 0;
    tgt = '0;
    for (k = 0; k < n; k++) begin
      if (hold == 0) begin
        tgt = pick_target();
        hold = $urandom_range(1, 40);
      end
      hold--;
      make_demands(a, b, c);
      if ($urandom_range(0, 9) == 0)
        send_tick(speed_t'($urandom), a, b, c);
      else
        send_tick(tgt, a, b, c);
    end
  endtask

  initial begin
    int      k;
    int      n;
    demand_t a;
    demand_t b;
    demand_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values: ties, extremes, stop code
    send_tick('0, '0, '0, '0);
    send_tick(8'd255, 10'd1023, 10'd1023, 10'd1023);
    send_tick(8'd255, '0, 10'd1023, 10'd1023);
    send_tick(8'd255, '0, '0, 10'd1023);
    send_tick(8'd255, 10'd1023, '0, '0);
    send_tick(8'd255, 10'd600, 10'd610, 10'd590);
    send_tick(STOP_CODE, 10'd5, '0, 10'd1023);
    send_tick('0, 10'd10, 10'd20, 10'd30);
    for (k = 0; k < 4; k++) send_tick(STOP_CODE, 10'd300, 10'd300, 10'd301);
    settle();

    // Directed, fast steps everywhere and cap below floor
    load_regs('0, 8'd15, '0, 8'd15, '0, 8'd255, 1'b1);
    for (k = 0; k < 4; k++) send_tick(8'd255, 10'd512, 10'd511, 10'd513);
    send_tick('0, 10'd1, 10'd2, 10'd3);
    send_tick(STOP_CODE, 10'd1023, 10'd1023, '0);
    settle();

    // Directed, zero steps (upper data bits dropped), widest limits
    load_regs('0, 8'hF0, '0, '0, 8'd255, '0, 1'b0);
    send_tick(8'd255, 10'd100, 10'd90, 10'd110);
    send_tick(8'd255, 10'd100, 10'd90, 10'd110);
    send_tick('0, 10'd7, 10'd7, 10'd7);
    send_tick('0, 10'd7, 10'd8, 10'd7);
    settle();

    // Random phases with fresh settings each time
    n = 0;
    while (n < RANDOM_TICKS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0)
        load_regs(RST_ACCEL_KNEE, speed_t'(RST_ACCEL_FAST_STEP), RST_DECEL_KNEE,
                  speed_t'(RST_DECEL_FAST_STEP), RST_SPEED_CAP, RST_SPEED_FLOOR, 1'b0);
      else
        load_regs(pick_byte(RST_ACCEL_KNEE), pick_step(RST_ACCEL_FAST_STEP),
                  pick_byte(RST_DECEL_KNEE), pick_step(RST_DECEL_FAST_STEP),
                  pick_cap(), pick_floor(), $urandom_range(0, 3) == 0);
      k = $urandom_range(60, 200);
      run_random_phase(k);
      n += k;
      settle();
    end

    repeat (5) @(posedge clk);
    if (tracker.n_bad == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
